// ----- rtl/lsfg_pkg.sv -----
package lsfg_pkg;

	localparam int START_WORDS = 1;
	localparam int COLOR_W = 24;
	localparam logic [7:0] LED_HDR = 8'hE0;
	localparam logic [31:0] END_WORD = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_SET_ONE = 2'd0,
		OP_SET_ALL = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_REFRESH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_BLUE_FIRST = 2'd1,
		REG_UPDATE_EN  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		WK_START,
		WK_LED,
		WK_END
	} word_kind_t;

	typedef struct packed {
		logic       wr_en;
		logic       wr_in;
		logic       clr_all;
		logic       emit;
		word_kind_t kind;
		logic       last;
	} ctrl_t;

endpackage

// ----- rtl/lsfg_ram.sv -----
module lsfg_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/lsfg_seq.sv -----
module lsfg_seq #(
	parameter int LED_COUNT = 32,
	parameter int END_WORDS = 1
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  lsfg_pkg::op_t                                 op,
	input  logic [4:0]                                    led_index,
	input  logic                                          upd_en,
	output logic                                          busy,
	output logic [(LED_COUNT > 1 ? $clog2(LED_COUNT) : 1)-1:0] addr,
	output lsfg_pkg::ctrl_t                               ctrl
);

	import lsfg_pkg::*;

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int TOTAL = START_WORDS + LED_COUNT + END_WORDS;
	localparam int CW = $clog2(TOTAL + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(TOTAL - 1);
	localparam logic [CW-1:0] FILL_LAST = CW'(LED_COUNT - 1);
	localparam logic [CW-1:0] LED_END = CW'(START_WORDS + LED_COUNT);
	localparam logic [CW-1:0] START_END = CW'(START_WORDS);
	localparam logic [CW-1:0] LEAD = CW'(START_WORDS - 1);
	localparam logic [CW-1:0] LED_CNT = CW'(LED_COUNT);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FILL,
		S_SEND
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_idx;
	logic          idx_ok;

	assign busy = (state_q != S_IDLE);
	assign idx_ok = ({27'd0, led_index} < 32'(LED_COUNT));
	// In each send cycle the store is read one entry ahead of the word being formed.
	assign rd_idx = cnt_q - LEAD;

	always_comb begin
		ctrl = '0;
		ctrl.kind = WK_START;
		addr = '0;
		case (state_q)
			S_IDLE: begin
				if (start && upd_en) begin
					case (op)
						OP_SET_ONE: begin
							ctrl.wr_en = idx_ok;
							ctrl.wr_in = 1'b1;
							addr = AW'(led_index);
						end
						OP_CLEAR: begin
							ctrl.clr_all = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_FILL: begin
				ctrl.wr_en = 1'b1;
				addr = cnt_q[AW-1:0];
			end
			S_SEND: begin
				ctrl.emit = 1'b1;
				ctrl.last = (cnt_q == LAST_CNT);
				if (rd_idx < LED_CNT) begin
					addr = rd_idx[AW-1:0];
				end
				if (cnt_q < START_END) begin
					ctrl.kind = WK_START;
				end else if (cnt_q < LED_END) begin
					ctrl.kind = WK_LED;
				end else begin
					ctrl.kind = WK_END;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (start && upd_en) begin
						if (op == OP_SET_ALL) begin
							state_q <= S_FILL;
						end else if (op == OP_REFRESH) begin
							state_q <= S_SEND;
						end
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == FILL_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_SEND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CNT) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/led_strip_frame_generator.sv -----
// Set-one and clear never raise busy; set-all keeps busy high while the RAM is filled.
// A refresh keeps busy high for the whole frame, set by one shared counter that reads
// the pixel RAM one entry per cycle.
// Words are registered out once the send state is entered, then one word per cycle.
// The receiver cannot stall; each word is valid for exactly one cycle.
// Reset clears every pixel through per-entry valid bits and restores the registers.
module led_strip_frame_generator #(
	parameter int LED_COUNT = 32,
	parameter int END_WORDS = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [4:0]  led_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic [31:0] frame_word,
	output logic        last_word,
	output logic        word_valid,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	import lsfg_pkg::*;

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	logic [4:0]           brightness_q;
	logic                 blue_first_q;
	logic                 update_en_q;
	logic [COLOR_W-1:0]   color_q;
	logic [LED_COUNT-1:0] valid_q;
	logic                 vld_s1;
	logic [31:0]          frame_word_q;
	logic                 last_word_q;
	logic                 word_valid_q;

	logic [AW-1:0]        addr;
	ctrl_t                ctrl;
	logic [COLOR_W-1:0]   wdata;
	logic [COLOR_W-1:0]   rdata;
	logic [COLOR_W-1:0]   px;
	logic [7:0]           first_c;
	logic [7:0]           third_c;
	logic [31:0]          led_w;
	logic [31:0]          word_d;

	lsfg_seq #(
		.LED_COUNT(LED_COUNT),
		.END_WORDS(END_WORDS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (op_t'(opcode)),
		.led_index(led_index),
		.upd_en   (update_en_q),
		.busy     (busy),
		.addr     (addr),
		.ctrl     (ctrl)
	);

	assign wdata = ctrl.wr_in ? {red, green, blue} : color_q;

	lsfg_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(LED_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.wr_en),
		.waddr(addr),
		.wdata(wdata),
		.raddr(addr),
		.rdata(rdata)
	);

	// An entry that has not been written since reset or the last clear reads as black.
	assign px = vld_s1 ? rdata : '0;
	assign first_c = blue_first_q ? px[7:0] : px[23:16];
	assign third_c = blue_first_q ? px[23:16] : px[7:0];
	assign led_w = {LED_HDR | {3'b000, brightness_q}, first_c, px[15:8], third_c};

	always_comb begin
		case (ctrl.kind)
			WK_START: word_d = '0;
			WK_LED:   word_d = led_w;
			WK_END:   word_d = END_WORD;
			default:  word_d = END_WORD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= 5'd31;
			blue_first_q <= 1'b0;
			update_en_q <= 1'b1;
			valid_q <= '0;
			word_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_BRIGHTNESS: brightness_q <= cfg_data;
					REG_BLUE_FIRST: blue_first_q <= cfg_data[0];
					REG_UPDATE_EN:  update_en_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (ctrl.clr_all) begin
				valid_q <= '0;
			end else if (ctrl.wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			word_valid_q <= ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			color_q <= {red, green, blue};
		end
		vld_s1 <= valid_q[addr];
		frame_word_q <= word_d;
		last_word_q <= ctrl.last;
	end

	assign frame_word = frame_word_q;
	assign last_word = last_word_q;
	assign word_valid = word_valid_q;

endmodule

// ----- bench/led_strip_frame_generator_tb.sv -----
`timescale 1ns / 100ps

module led_strip_frame_generator_tb;

	import lsfg_pkg::*;

	localparam int LEDS = 32;
	localparam int ENDS = 1;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 190;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [7:0] BYTE_MASK = 8'hFF;

	typedef struct {
		op_t         op;
		logic [4:0]  idx;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		int unsigned gap;
	} strip_cmd_t;

	typedef struct {
		logic [31:0] word;
		logic        last;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  opcode = OP_SET_ONE;
	logic [4:0]  led_index = '0;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_BRIGHTNESS;
	logic [4:0]  cfg_data = '0;
	wire         busy;
	wire  [31:0] frame_word;
	wire         last_word;
	wire         word_valid;

	strip_cmd_t  cmd_q[$];
	strip_cmd_t  cur_cmd;
	frame_t      frame_q[$];
	frame_t      got_frame;
	int unsigned gap_cnt = 0;
	int unsigned fail_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned useful_items = 0;
	bit          no_gaps = 1'b0;

	// Shadow copy of the pixel store and registers.
	logic [23:0] pix_model[LEDS];
	logic [4:0]  bright_model;
	logic        bgr_model;
	logic        upd_model;

	led_strip_frame_generator #(
		.LED_COUNT(LEDS),
		.END_WORDS(ENDS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.led_index(led_index),
		.red(red),
		.green(green),
		.blue(blue),
		.frame_word(frame_word),
		.last_word(last_word),
		.word_valid(word_valid),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, frame_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic note_failure(input string msg);
		if (fail_cnt < 10) begin
			$display("%0t: %s", $realtime, msg);
		end
		fail_cnt++;
	endtask

	function automatic void apply_command(input strip_cmd_t c);
		logic [23:0] px;
		logic [7:0]  first;
		logic [7:0]  third;
		frame_t      f;
		if (!upd_model) begin
			return;
		end
		case (c.op)
			OP_SET_ONE: begin
				if (c.idx < LEDS) begin
					pix_model[c.idx] = {c.r, c.g, c.b};
				end
			end
			OP_SET_ALL: begin
				foreach (pix_model[i]) pix_model[i] = {c.r, c.g, c.b};
			end
			OP_CLEAR: begin
				foreach (pix_model[i]) pix_model[i] = '0;
			end
			OP_REFRESH: begin
				for (int i = 0; i < START_WORDS; i++) begin
					f.word = '0;
					f.last = 1'b0;
					frame_q.push_back(f);
				end
				for (int i = 0; i < LEDS; i++) begin
					px = pix_model[i];
					first = bgr_model ? px[7:0] : px[23:16];
					third = bgr_model ? px[23:16] : px[7:0];
					f.word = {LED_HDR | {3'b000, bright_model}, first, px[15:8] & BYTE_MASK, third};
					f.last = 1'b0;
					frame_q.push_back(f);
				end
				for (int i = 0; i < ENDS; i++) begin
					f.word = END_WORD;
					f.last = (i == ENDS - 1);
					frame_q.push_back(f);
				end
			end
			default: ;
		endcase
	endfunction

	// Command driver: start stays high until the transfer, then the next command follows
	// at once when its gap is zero.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_cnt <= 0;
		end else if (start && !busy) begin
			apply_command(cur_cmd);
			if (cmd_q.size() > 0 && cmd_q[0].gap == 0) begin
				cur_cmd = cmd_q.pop_front();
				opcode <= cur_cmd.op;
				led_index <= cur_cmd.idx;
				red <= cur_cmd.r;
				green <= cur_cmd.g;
				blue <= cur_cmd.b;
			end else begin
				start <= 1'b0;
				gap_cnt <= 0;
			end
		end else if (!start && cmd_q.size() > 0) begin
			if (gap_cnt < cmd_q[0].gap) begin
				gap_cnt <= gap_cnt + 1;
			end else begin
				cur_cmd = cmd_q.pop_front();
				opcode <= cur_cmd.op;
				led_index <= cur_cmd.idx;
				red <= cur_cmd.r;
				green <= cur_cmd.g;
				blue <= cur_cmd.b;
				start <= 1'b1;
				gap_cnt <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && word_valid) begin
			if (frame_q.size() == 0) begin
				note_failure($sformatf("unexpected word %h last %b", frame_word, last_word));
			end else begin
				got_frame = frame_q.pop_front();
				if (frame_word !== got_frame.word || last_word !== got_frame.last) begin
					note_failure($sformatf("word %h last %b, expected %h last %b",
						frame_word, last_word, got_frame.word, got_frame.last));
				end
			end
		end
	end

	task automatic add_cmd(input op_t op, input logic [4:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		strip_cmd_t c;
		c.op = op;
		c.idx = idx;
		c.r = r;
		c.g = g;
		c.b = b;
		c.gap = no_gaps ? 0 : $urandom_range(0, 4);
		cmd_q.push_back(c);
		if (upd_model) begin
			useful_items++;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BRIGHTNESS: bright_model = (val > 5'd31) ? 5'd31 : val;
			REG_BLUE_FIRST: bgr_model = val[0];
			REG_UPDATE_EN:  upd_model = val[0];
			default: ;
		endcase
	endtask

	// Let all queued commands go through and the last frame drain before touching registers.
	task automatic wait_idle();
		do begin
			@(posedge clk);
		end while (cmd_q.size() > 0 || start || frame_q.size() > 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic add_random_cmd();
		int unsigned pick;
		op_t         op;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			op = OP_SET_ONE;
		end else if (pick < 55) begin
			op = OP_SET_ALL;
		end else if (pick < 62) begin
			op = OP_CLEAR;
		end else begin
			op = OP_REFRESH;
		end
		add_cmd(op, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int unsigned phase;
		int unsigned n_items;
		foreach (pix_model[i]) pix_model[i] = '0;
		bright_model = 5'd31;
		bgr_model = 1'b0;
		upd_model = 1'b1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: store contents after reset, corner colors and indexes, every command.
		add_cmd(OP_REFRESH, 5'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(OP_SET_ONE, 5'd0, 8'hFF, 8'h00, 8'h00);
		add_cmd(OP_SET_ONE, 5'd31, 8'h00, 8'hFF, 8'hFF);
		add_cmd(OP_SET_ONE, 5'd5, 8'h12, 8'h34, 8'h56);
		add_cmd(OP_REFRESH, 5'd31, 8'hFF, 8'hFF, 8'hFF);
		add_cmd(OP_SET_ALL, 5'd0, 8'hAA, 8'h55, 8'h0F);
		add_cmd(OP_SET_ONE, 5'd16, 8'hFF, 8'hFF, 8'hFF);
		add_cmd(OP_REFRESH, 5'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(OP_CLEAR, 5'd7, 8'h11, 8'h22, 8'h33);
		add_cmd(OP_REFRESH, 5'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(OP_SET_ONE, 5'd1, 8'h01, 8'h80, 8'hFE);
		wait_idle();

		write_reg(REG_BRIGHTNESS, 5'd0);
		write_reg(REG_BLUE_FIRST, 5'h01);
		add_cmd(OP_SET_ONE, 5'd2, 8'hC3, 8'h3C, 8'h5A);
		add_cmd(OP_REFRESH, 5'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();

		// Only bit 0 of the blue-first register counts.
		write_reg(REG_BLUE_FIRST, 5'h1E);
		write_reg(REG_BRIGHTNESS, 5'd17);
		add_cmd(OP_REFRESH, 5'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();

		write_reg(REG_UPDATE_EN, 5'h10);
		add_cmd(OP_SET_ALL, 5'd0, 8'hFF, 8'hFF, 8'hFF);
		add_cmd(OP_CLEAR, 5'd0, 8'h00, 8'h00, 8'h00);
		add_cmd(OP_SET_ONE, 5'd2, 8'h00, 8'h00, 8'h00);
		add_cmd(OP_REFRESH, 5'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();

		write_reg(REG_UPDATE_EN, 5'h0F);
		write_reg(REG_UNUSED, 5'h1F);
		write_reg(REG_BRIGHTNESS, 5'd31);
		add_cmd(OP_REFRESH, 5'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();

		useful_items = 0;
		phase = 0;
		while (useful_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: write_reg(REG_BRIGHTNESS, 5'd0);
				1: write_reg(REG_BRIGHTNESS, 5'd31);
				default: write_reg(REG_BRIGHTNESS, 5'($urandom));
			endcase
			write_reg(REG_BLUE_FIRST, 5'($urandom));
			if (phase % 5 == 3) begin
				write_reg(REG_UPDATE_EN, {4'($urandom), 1'b0});
			end else begin
				write_reg(REG_UPDATE_EN, {4'($urandom), 1'b1});
			end
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_UNUSED, 5'($urandom));
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			n_items = upd_model ? $urandom_range(20, 35) : 6;
			repeat (n_items) add_random_cmd();
			wait_idle();
			phase++;
		end

		if (fail_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d failures", fail_cnt);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
